// ===== design/klbs_pkg.sv =====
// Package for the keyword lexer: token kind codes, keyword spellings, limits.
// No dependencies; the lexer top level and its checker import it.
package klbs_pkg;

    localparam int unsigned KIND_W = 5;
    localparam int unsigned LEN_W  = 5;
    localparam int unsigned PREFIX_CHARS = 7;
    localparam int unsigned PREFIX_W = 8 * PREFIX_CHARS;

    // Longest token the block handles; register values above it are clamped.
    localparam logic [LEN_W-1:0] MAX_TOKEN_CHARS = 5'd20;

    localparam logic [LEN_W-1:0] WORD_LEN_RESET = 5'd20;
    localparam logic [LEN_W-1:0] NUM_LEN_RESET  = 5'd12;

    // Configuration register indexes
    localparam logic REG_MAX_WORD = 1'b0;
    localparam logic REG_MAX_NUM  = 1'b1;

    typedef enum logic [KIND_W-1:0] {
        KIND_ID      = 5'd0,
        KIND_NUM     = 5'd1,
        KIND_PROGRAM = 5'd2,
        KIND_CONST   = 5'd3,
        KIND_VAR     = 5'd4,
        KIND_BEGIN   = 5'd5,
        KIND_END_KW  = 5'd6,
        KIND_IF      = 5'd7,
        KIND_THEN    = 5'd8,
        KIND_WHILE   = 5'd9,
        KIND_DO      = 5'd10,
        KIND_WRITE   = 5'd11,
        KIND_READ    = 5'd12,
        KIND_SEMI    = 5'd13,
        KIND_DOT     = 5'd14,
        KIND_PLUS    = 5'd15,
        KIND_MINUS   = 5'd16,
        KIND_STAR    = 5'd17,
        KIND_SLASH   = 5'd18,
        KIND_COMMA   = 5'd19,
        KIND_ASSIGN  = 5'd20,
        KIND_LT      = 5'd21,
        KIND_LE      = 5'd22,
        KIND_NE      = 5'd23,
        KIND_GT      = 5'd24,
        KIND_GE      = 5'd25,
        KIND_LPAREN  = 5'd26,
        KIND_RPAREN  = 5'd27,
        KIND_EQ      = 5'd28,
        KIND_ERROR   = 5'd29,
        KIND_EOF     = 5'd30
    } t_kind;

    // Lowercase keyword spellings, last character in the low byte
    localparam logic [PREFIX_W-1:0] KW_PROGRAM = 56'h70726F6772616D;
    localparam logic [PREFIX_W-1:0] KW_CONST   = 56'h636F6E7374;
    localparam logic [PREFIX_W-1:0] KW_VAR     = 56'h766172;
    localparam logic [PREFIX_W-1:0] KW_BEGIN   = 56'h626567696E;
    localparam logic [PREFIX_W-1:0] KW_END     = 56'h656E64;
    localparam logic [PREFIX_W-1:0] KW_IF      = 56'h6966;
    localparam logic [PREFIX_W-1:0] KW_THEN    = 56'h7468656E;
    localparam logic [PREFIX_W-1:0] KW_WHILE   = 56'h7768696C65;
    localparam logic [PREFIX_W-1:0] KW_DO      = 56'h646F;
    localparam logic [PREFIX_W-1:0] KW_WRITE   = 56'h7772697465;
    localparam logic [PREFIX_W-1:0] KW_READ    = 56'h72656164;

    typedef struct packed {
        t_kind            kind;
        logic [LEN_W-1:0] len;
        logic             last;
    } t_token;

endpackage

// ===== design/keyword_lexer_byte_stream.sv =====
// Keyword lexer top level: input register, one-pass scan logic, token queue.
// Depends on klbs_pkg for token codes and keyword constants.
//
//  channel   dir  handshake            payload
//  s_*       in   s_tvalid / s_tready  s_tdata = char_code, s_tuser = end_of_input
//  m_*       out  m_tvalid / m_tready  m_tdata = {length, kind}, m_tlast = last
//  APB       in   psel+penable+pwrite  reg 0 max_word_length, reg 1 max_number_length
//
// A byte is taken every cycle unless scanning stalls. It is held in the input
// register, then scanned, and its 0..2 tokens enter a 4-entry queue; the queue
// drains one token per cycle while m_tready is high.
// Scanning stalls only while the queue holds more than two tokens.
// i_rst_n is synchronous, active low; it clears scan state, queue and registers.
module keyword_lexer_byte_stream
    import klbs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_code
    input  logic        s_tuser,   // [0] end_of_input
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [4:0] token_kind, [9:5] token_length, rest 0
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    typedef enum logic [6:0] {
        S_IDLE    = 7'b0000001,
        S_WORD    = 7'b0000010,
        S_NUM     = 7'b0000100,
        S_PEND    = 7'b0001000,
        S_BRACE   = 7'b0010000,
        S_COMMENT = 7'b0100000,
        S_CSTAR   = 7'b1000000
    } t_mode;

    // configuration
    logic [LEN_W-1:0] r_max_word, r_max_num;
    logic [LEN_W-1:0] word_lim, num_lim;

    // input register
    logic       r_in_valid;
    logic [7:0] r_char;
    logic       r_eoi;

    // scan state
    t_mode               r_mode, n_mode;
    logic [LEN_W-1:0]    r_len, n_len;
    logic [PREFIX_W-1:0] r_prefix, n_prefix;
    logic [7:0]          r_pend, n_pend;
    logic                r_ovf, n_ovf;

    // token queue
    t_token     r_q [4];
    logic [1:0] r_head, r_tail;
    logic [2:0] r_cnt;

    logic proc, pop;

    // first token (from the current mode) and second (rescan or end mark)
    logic             a_v, b_v;
    t_kind            a_kind, b_kind;
    logic [LEN_W-1:0] a_len, b_len;

    // result of scanning the byte from the idle mode
    t_mode               i_mode;
    logic [LEN_W-1:0]    i_len;
    logic [PREFIX_W-1:0] i_prefix;
    logic [7:0]          i_pend;
    logic                i_v;
    t_kind               i_kind;

    logic       is_let, is_dig, rescan;
    logic [7:0] lc;

    function automatic t_kind word_kind(logic [PREFIX_W-1:0] p, logic [LEN_W-1:0] n);
        t_kind k;
        k = KIND_ID;
        if      (n == 5'd7 && p == KW_PROGRAM) k = KIND_PROGRAM;
        else if (n == 5'd5 && p == KW_CONST)   k = KIND_CONST;
        else if (n == 5'd3 && p == KW_VAR)     k = KIND_VAR;
        else if (n == 5'd5 && p == KW_BEGIN)   k = KIND_BEGIN;
        else if (n == 5'd3 && p == KW_END)     k = KIND_END_KW;
        else if (n == 5'd2 && p == KW_IF)      k = KIND_IF;
        else if (n == 5'd4 && p == KW_THEN)    k = KIND_THEN;
        else if (n == 5'd5 && p == KW_WHILE)   k = KIND_WHILE;
        else if (n == 5'd2 && p == KW_DO)      k = KIND_DO;
        else if (n == 5'd5 && p == KW_WRITE)   k = KIND_WRITE;
        else if (n == 5'd4 && p == KW_READ)    k = KIND_READ;
        return k;
    endfunction

    function automatic t_kind lone_kind(logic [7:0] p);
        t_kind k;
        k = KIND_ERROR;
        if (p == "<")      k = KIND_LT;
        else if (p == ">") k = KIND_GT;
        return k;
    endfunction

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_MAX_NUM) ? {27'd0, r_max_num} : {27'd0, r_max_word};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_word <= WORD_LEN_RESET;
            r_max_num  <= NUM_LEN_RESET;
        end else if (psel && penable && pwrite && pready) begin
            if (paddr[2] == REG_MAX_WORD) r_max_word <= pwdata[LEN_W-1:0];
            else                          r_max_num  <= pwdata[LEN_W-1:0];
        end
    end

    // zero acts as one, above the ceiling clamps
    assign word_lim = (r_max_word == '0) ? 5'd1 :
                      (r_max_word > MAX_TOKEN_CHARS) ? MAX_TOKEN_CHARS : r_max_word;
    assign num_lim  = (r_max_num == '0) ? 5'd1 :
                      (r_max_num > MAX_TOKEN_CHARS) ? MAX_TOKEN_CHARS : r_max_num;

    // ---------------- input register ----------------
    assign proc     = r_in_valid && (r_cnt <= 3'd2);
    assign s_tready = !r_in_valid || proc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_tready) begin
            r_in_valid <= s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_tready && s_tvalid) begin
            r_char <= s_tdata;
            r_eoi  <= s_tuser;
        end
    end

    // ---------------- scan logic ----------------
    assign is_let = (r_char >= "A" && r_char <= "Z") || (r_char >= "a" && r_char <= "z");
    assign is_dig = (r_char >= "0" && r_char <= "9");
    assign lc     = is_let ? (r_char | 8'h20) : r_char;

    always_comb begin
        i_mode   = S_IDLE;
        i_len    = '0;
        i_prefix = '0;
        i_pend   = '0;
        i_v      = 1'b0;
        i_kind   = KIND_ERROR;
        if (r_char == " " || r_char == 8'h09 || r_char == 8'h0A) begin
            i_mode = S_IDLE;
        end else if (is_let) begin
            i_mode   = S_WORD;
            i_len    = 5'd1;
            i_prefix = {{(PREFIX_W-8){1'b0}}, lc};
        end else if (is_dig) begin
            i_mode = S_NUM;
            i_len  = 5'd1;
        end else begin
            case (r_char) inside
                ":", "<", ">": begin
                    i_mode = S_PEND;
                    i_pend = r_char;
                end
                "{": i_mode = S_BRACE;
                ";": begin i_v = 1'b1; i_kind = KIND_SEMI;   end
                ".": begin i_v = 1'b1; i_kind = KIND_DOT;    end
                "+": begin i_v = 1'b1; i_kind = KIND_PLUS;   end
                "-": begin i_v = 1'b1; i_kind = KIND_MINUS;  end
                "*": begin i_v = 1'b1; i_kind = KIND_STAR;   end
                "/": begin i_v = 1'b1; i_kind = KIND_SLASH;  end
                ",": begin i_v = 1'b1; i_kind = KIND_COMMA;  end
                "(": begin i_v = 1'b1; i_kind = KIND_LPAREN; end
                ")": begin i_v = 1'b1; i_kind = KIND_RPAREN; end
                "=": begin i_v = 1'b1; i_kind = KIND_EQ;     end
                default: begin i_v = 1'b1; i_kind = KIND_ERROR; end
            endcase
        end
    end

    always_comb begin
        n_mode   = r_mode;
        n_len    = r_len;
        n_prefix = r_prefix;
        n_pend   = r_pend;
        n_ovf    = r_ovf;
        a_v      = 1'b0;
        a_kind   = KIND_ERROR;
        a_len    = 5'd1;
        b_v      = 1'b0;
        b_kind   = KIND_EOF;
        b_len    = '0;
        rescan   = 1'b0;

        if (r_eoi) begin
            unique case (r_mode)
                S_WORD:  if (!r_ovf) begin a_v = 1'b1; a_kind = word_kind(r_prefix, r_len);
                                         a_len = r_len; end
                S_NUM:   if (!r_ovf) begin a_v = 1'b1; a_kind = KIND_NUM; a_len = r_len; end
                S_PEND:  begin a_v = 1'b1; a_kind = lone_kind(r_pend); end
                S_BRACE: a_v = 1'b1;
                S_IDLE, S_COMMENT, S_CSTAR: a_v = 1'b0;
                default: a_v = 1'b0;
            endcase
            b_v      = 1'b1;
            n_mode   = S_IDLE;
            n_len    = '0;
            n_prefix = '0;
            n_pend   = '0;
            n_ovf    = 1'b0;
        end else begin
            unique case (r_mode)
                S_WORD, S_NUM: begin
                    if ((r_mode == S_WORD) ? (is_let || is_dig) : is_dig) begin
                        if (!r_ovf) begin
                            if (r_len >= ((r_mode == S_WORD) ? word_lim : num_lim)) begin
                                // run too long: report once, drop the rest
                                a_v   = 1'b1;
                                a_len = r_len;
                                n_ovf = 1'b1;
                            end else begin
                                if (r_mode == S_WORD && r_len < 5'(PREFIX_CHARS))
                                    n_prefix = {r_prefix[PREFIX_W-9:0], lc};
                                n_len = r_len + 5'd1;
                            end
                        end
                    end else begin
                        if (!r_ovf) begin
                            a_v    = 1'b1;
                            a_len  = r_len;
                            a_kind = (r_mode == S_WORD) ? word_kind(r_prefix, r_len) : KIND_NUM;
                        end
                        rescan = 1'b1;
                    end
                end
                S_PEND: begin
                    a_v   = 1'b1;
                    a_len = 5'd2;
                    if (r_pend == ":" && r_char == "=")      a_kind = KIND_ASSIGN;
                    else if (r_pend == "<" && r_char == "=") a_kind = KIND_LE;
                    else if (r_pend == "<" && r_char == ">") a_kind = KIND_NE;
                    else if (r_pend == ">" && r_char == "=") a_kind = KIND_GE;
                    else begin
                        a_kind = lone_kind(r_pend);
                        a_len  = 5'd1;
                        rescan = 1'b1;
                    end
                    n_mode = S_IDLE;
                    n_pend = '0;
                end
                S_BRACE: begin
                    if (r_char == "*") begin
                        n_mode = S_COMMENT;
                    end else begin
                        a_v    = 1'b1;
                        rescan = 1'b1;
                    end
                end
                S_COMMENT: if (r_char == "*") n_mode = S_CSTAR;
                S_CSTAR: begin
                    if (r_char == "}")      n_mode = S_IDLE;
                    else if (r_char != "*") n_mode = S_COMMENT;
                end
                S_IDLE:  rescan = 1'b1;
                default: rescan = 1'b1;
            endcase
            if (rescan) begin
                n_mode   = i_mode;
                n_len    = i_len;
                n_prefix = i_prefix;
                n_pend   = i_pend;
                n_ovf    = 1'b0;
                b_v      = i_v;
                b_kind   = i_kind;
                b_len    = 5'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= S_IDLE;
            r_len    <= '0;
            r_prefix <= '0;
            r_pend   <= '0;
            r_ovf    <= 1'b0;
        end else if (proc) begin
            r_mode   <= n_mode;
            r_len    <= n_len;
            r_prefix <= n_prefix;
            r_pend   <= n_pend;
            r_ovf    <= n_ovf;
        end
    end

    // ---------------- token queue ----------------
    assign pop      = m_tvalid && m_tready;
    assign m_tvalid = (r_cnt != 3'd0);
    assign m_tdata  = {6'd0, r_q[r_head].len, r_q[r_head].kind};
    assign m_tlast  = r_q[r_head].last;

    always_ff @(posedge i_clk) begin
        if (proc) begin
            if (a_v) r_q[r_tail] <= '{kind: a_kind, len: a_len, last: !b_v};
            if (b_v) r_q[a_v ? r_tail + 2'd1 : r_tail] <= '{kind: b_kind, len: b_len,
                                                             last: 1'b1};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
            r_cnt  <= '0;
        end else begin
            if (pop) r_head <= r_head + 2'd1;
            if (proc) r_tail <= r_tail + {1'b0, a_v} + {1'b0, b_v};
            r_cnt <= r_cnt + (proc ? ({2'b0, a_v} + {2'b0, b_v}) : 3'd0)
                           - {2'b0, pop};
        end
    end

endmodule

// ===== design/keyword_lexer_byte_stream_chk.sv =====
// Port-level checker for the keyword lexer, bound to the top level.
// Depends on klbs_pkg for token kind codes and the length ceiling.
module keyword_lexer_byte_stream_chk
    import klbs_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tlast
);

    // a stalled token stays offered
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $past(m_tvalid && !m_tready) |-> m_tvalid)
        else $error("token dropped while stalled");

    // end mark closes its transaction group and carries no characters
    a_eof_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tdata[4:0] == KIND_EOF |-> m_tlast && m_tdata[9:5] == '0)
        else $error("end token without tlast or with nonzero length");

    // kinds and lengths stay in range
    a_ranges: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> m_tdata[4:0] <= KIND_EOF && m_tdata[9:5] <= MAX_TOKEN_CHARS
                     && m_tdata[15:10] == '0)
        else $error("token kind or length out of range");

    // only the end token has zero length
    a_len_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tdata[9:5] == '0 |-> m_tdata[4:0] == KIND_EOF)
        else $error("zero-length token that is not the end token");

endmodule

bind keyword_lexer_byte_stream keyword_lexer_byte_stream_chk u_chk (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for keyword_lexer_byte_stream: byte stream in, token stream out.
// Depends on klbs_pkg and the lexer top level; everything else is generated here.

module tb_top;
    import klbs_pkg::*;

    localparam int N_PHASES    = 7;
    localparam int PHASE_ITEMS = 195;
    localparam int RX_HOLD     = 300;

    // lookup for the keyword match, spelled as in the package constants
    localparam logic [PREFIX_W-1:0] KW_SPELL [11] = '{KW_PROGRAM, KW_CONST, KW_VAR,
        KW_BEGIN, KW_END, KW_IF, KW_THEN, KW_WHILE, KW_DO, KW_WRITE, KW_READ};
    localparam int KW_CHARS [11] = '{7, 5, 3, 5, 3, 2, 4, 5, 2, 5, 4};

    typedef enum logic [2:0] {
        SC_IDLE, SC_WORD, SC_NUM, SC_PEND, SC_BRACE, SC_COMMENT, SC_CSTAR
    } t_scan;

    class lexer_scoreboard;
        t_token           expected_q[$];
        t_token           byte_tokens[$];
        int unsigned      mismatch_count;
        int unsigned      n_checked;
        int unsigned      n_bytes;
        logic [LEN_W-1:0] word_reg;
        logic [LEN_W-1:0] num_reg;
        t_scan            mode;
        int               run_len;
        logic [PREFIX_W-1:0] prefix;
        logic [7:0]       pend;
        bit               ovf;

        function new();
            word_reg = WORD_LEN_RESET;
            num_reg  = NUM_LEN_RESET;
            clear_run();
        endfunction

        function int lim_of(logic [LEN_W-1:0] r);
            if (r == 0) return 1;
            if (r > MAX_TOKEN_CHARS) return MAX_TOKEN_CHARS;
            return r;
        endfunction

        function bit is_letter(logic [7:0] c);
            return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
        endfunction

        function bit is_digit(logic [7:0] c);
            return c >= "0" && c <= "9";
        endfunction

        function void clear_run();
            mode    = SC_IDLE;
            run_len = 0;
            prefix  = '0;
            pend    = '0;
            ovf     = 1'b0;
        endfunction

        // a byte yields two tokens at most
        function void add(t_kind k, int len);
            t_token tk;
            if (byte_tokens.size() >= 2) return;
            tk.kind = k;
            tk.len  = len[LEN_W-1:0];
            tk.last = 1'b0;
            byte_tokens.push_back(tk);
        endfunction

        function void add_word();
            if (run_len <= PREFIX_CHARS) begin
                for (int k = 0; k < 11; k++) begin
                    if (run_len == KW_CHARS[k] && prefix == KW_SPELL[k]) begin
                        add(t_kind'(KIND_PROGRAM + k), run_len);
                        return;
                    end
                end
            end
            add(KIND_ID, run_len);
        endfunction

        function void add_lone_pend();
            if (pend == "<") add(KIND_LT, 1);
            else if (pend == ">") add(KIND_GT, 1);
            else add(KIND_ERROR, 1);
        endfunction

        function void scan_idle(logic [7:0] c);
            clear_run();
            if (c == " " || c == "\t" || c == "\n") return;
            if (is_letter(c)) begin
                mode    = SC_WORD;
                run_len = 1;
                prefix  = {{(PREFIX_W-8){1'b0}}, c | 8'h20};
                return;
            end
            if (is_digit(c)) begin
                mode    = SC_NUM;
                run_len = 1;
                return;
            end
            case (c)
                ":", "<", ">": begin
                    mode = SC_PEND;
                    pend = c;
                end
                "{": mode = SC_BRACE;
                ";": add(KIND_SEMI, 1);
                ".": add(KIND_DOT, 1);
                "+": add(KIND_PLUS, 1);
                "-": add(KIND_MINUS, 1);
                "*": add(KIND_STAR, 1);
                "/": add(KIND_SLASH, 1);
                ",": add(KIND_COMMA, 1);
                "(": add(KIND_LPAREN, 1);
                ")": add(KIND_RPAREN, 1);
                "=": add(KIND_EQ, 1);
                default: add(KIND_ERROR, 1);
            endcase
        endfunction

        // returns 1 when the byte belongs to the current run
        function bit take_run(bit member, int lim, logic [7:0] c, bit word);
            logic [7:0] lc;
            if (!member) return 1'b0;
            if (ovf) return 1'b1;
            if (run_len >= lim) begin
                add(KIND_ERROR, run_len);
                ovf = 1'b1;
                return 1'b1;
            end
            if (word && run_len < PREFIX_CHARS) begin
                lc     = is_letter(c) ? (c | 8'h20) : c;
                prefix = {prefix[PREFIX_W-9:0], lc};
            end
            run_len++;
            return 1'b1;
        endfunction

        function void note_input(logic [7:0] c, logic eoi);
            byte_tokens.delete();
            n_bytes++;
            if (eoi) begin
                if (mode == SC_WORD && !ovf) add_word();
                else if (mode == SC_NUM && !ovf) add(KIND_NUM, run_len);
                else if (mode == SC_PEND) add_lone_pend();
                else if (mode == SC_BRACE) add(KIND_ERROR, 1);
                add(KIND_EOF, 0);
                clear_run();
            end else begin
                case (mode)
                    SC_WORD: begin
                        if (!take_run(is_letter(c) || is_digit(c), lim_of(word_reg), c, 1'b1))
                        begin
                            if (!ovf) add_word();
                            scan_idle(c);
                        end
                    end
                    SC_NUM: begin
                        if (!take_run(is_digit(c), lim_of(num_reg), c, 1'b0)) begin
                            if (!ovf) add(KIND_NUM, run_len);
                            scan_idle(c);
                        end
                    end
                    SC_PEND: begin
                        if (pend == ":" && c == "=") begin
                            add(KIND_ASSIGN, 2);
                            clear_run();
                        end else if (pend == "<" && c == "=") begin
                            add(KIND_LE, 2);
                            clear_run();
                        end else if (pend == "<" && c == ">") begin
                            add(KIND_NE, 2);
                            clear_run();
                        end else if (pend == ">" && c == "=") begin
                            add(KIND_GE, 2);
                            clear_run();
                        end else begin
                            add_lone_pend();
                            scan_idle(c);
                        end
                    end
                    SC_BRACE: begin
                        if (c == "*") mode = SC_COMMENT;
                        else begin
                            add(KIND_ERROR, 1);
                            scan_idle(c);
                        end
                    end
                    SC_COMMENT: if (c == "*") mode = SC_CSTAR;
                    SC_CSTAR: begin
                        if (c == "}") clear_run();
                        else if (c != "*") mode = SC_COMMENT;
                    end
                    default: scan_idle(c);
                endcase
            end
            if (byte_tokens.size() > 0) byte_tokens[byte_tokens.size()-1].last = 1'b1;
            foreach (byte_tokens[i]) expected_q.push_back(byte_tokens[i]);
        endfunction

        function void check_result(logic [KIND_W-1:0] kind, logic [LEN_W-1:0] len, logic last);
            t_token exp_tok;
            if (expected_q.size() == 0) begin
                $error("unexpected token: kind %0d length %0d", kind, len);
                mismatch_count++;
                return;
            end
            exp_tok = expected_q.pop_front();
            n_checked++;
            if (exp_tok.kind !== kind) begin
                $error("token_kind: expected %0d, actual %0d", exp_tok.kind, kind);
                mismatch_count++;
            end
            if (exp_tok.len !== len) begin
                $error("token_length: expected %0d, actual %0d", exp_tok.len, len);
                mismatch_count++;
            end
            if (exp_tok.last !== last) begin
                $error("last: expected %0d, actual %0d", exp_tok.last, last);
                mismatch_count++;
            end
        endfunction
    endclass

    logic        i_clk    = 1'b0;
    logic        i_rst_n  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;   // [7:0] char_code
    logic        s_tuser  = 1'b0; // [0] end_of_input
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;         // [4:0] token_kind, [9:5] token_length
    logic        m_tlast;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    lexer_scoreboard sb = new();

    logic [8:0]  text_q[$];       // {end_of_input, char_code}
    int          burst_left = 0;
    bit          gaps_on    = 1'b1;
    int          rx_mode    = 0;
    bit          rx_hold_req = 1'b0;
    int          rx_hold_left = 0;
    int unsigned rx_cnt = 0;
    int unsigned word_cfg [N_PHASES] = '{20, 1, 20, 0, 7, 31, 0};
    int unsigned num_cfg  [N_PHASES] = '{12, 1, 20, 31, 5, 0, 0};
    int          rx_modes [N_PHASES] = '{1, 2, 0, 1, 2, 0, 1};
    string       op_text  [18] = '{";", ".", "+", "-", "*", "/", ",", ":=", "<", "<=",
                                   "<>", ">", ">=", "(", ")", "=", ":", "{"};
    string       kw_text  [11] = '{"program", "const", "var", "begin", "end", "if",
                                   "then", "while", "do", "write", "read"};

    keyword_lexer_byte_stream u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #4 i_clk = ~i_clk;

    // receiver: per-phase stall pattern, plus an occasional long hold-off
    always @(posedge i_clk) begin
        rx_cnt++;
        if (rx_hold_req) begin
            rx_hold_left = RX_HOLD;
            rx_hold_req  = 1'b0;
        end
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            m_tready <= 1'b0;
        end else begin
            case (rx_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= ($urandom_range(0, 3) != 0);
                default: m_tready <= ((rx_cnt % 7) < 3);
            endcase
        end
    end

    // transaction monitor
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata[KIND_W-1:0], m_tdata[KIND_W+LEN_W-1:KIND_W], m_tlast);
            if (s_tvalid && s_tready) sb.note_input(s_tdata, s_tuser);
        end
    end

    initial begin
        #(5_000_000);
        $display("timeout: %0d tokens still outstanding", sb.expected_q.size());
        $display("** keyword_lexer_byte_stream: FAILED **");
        $finish;
    end

    task automatic send_byte(input logic [8:0] item);
        if (gaps_on && burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = $urandom_range(1, 12);
        end
        if (burst_left > 0) burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= item[8];
        s_tdata  <= item[7:0];
        do @(posedge i_clk); while (!s_tready);
    endtask

    task automatic wait_tokens_out();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.expected_q.size() != 0) @(posedge i_clk);
    endtask

    // write, then read back over APB; caller sits on a clock edge
    task automatic write_reg(input logic idx, input logic [LEN_W-1:0] value);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= {27'($urandom), value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (idx == REG_MAX_WORD) sb.word_reg = value;
        else sb.num_reg = value;
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata[LEN_W-1:0] !== value) begin
            $error("register %0d readback: expected %0d, actual %0d", idx, value,
                   prdata[LEN_W-1:0]);
            sb.mismatch_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic void push_text(string s, bit flip_case);
        logic [7:0] c;
        for (int i = 0; i < s.len(); i++) begin
            c = s[i];
            if (flip_case && sb.is_letter(c) && $urandom_range(0, 1)) c = c ^ 8'h20;
            text_q.push_back({1'b0, c});
        end
    endfunction

    function automatic logic [7:0] rand_alnum(bit letters_only);
        if (!letters_only && $urandom_range(0, 2) == 0) return 8'("0" + $urandom_range(0, 9));
        return 8'(($urandom_range(0, 1) ? "a" : "A") + $urandom_range(0, 25));
    endfunction

    // one lexeme at a time, mostly well formed, some noise and broken pieces
    function automatic void add_lexeme();
        int wl = sb.lim_of(sb.word_reg);
        int nl = sb.lim_of(sb.num_reg);
        int n;
        case ($urandom_range(0, 19))
            0, 1, 2, 3: push_text(kw_text[$urandom_range(0, 10)], 1'b1);
            4, 5, 6: begin
                n = ($urandom_range(0, 4) == 0) ? $urandom_range(1, wl + 3)
                                                : $urandom_range(1, (wl < 8) ? wl : 8);
                text_q.push_back({1'b0, rand_alnum(1'b1)});
                repeat (n - 1) text_q.push_back({1'b0, rand_alnum(1'b0)});
            end
            7, 8: begin
                n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, nl + 3)
                                                : $urandom_range(1, (nl < 6) ? nl : 6);
                repeat (n) text_q.push_back({1'b0, 8'("0" + $urandom_range(0, 9))});
            end
            9, 10, 11, 12: push_text(op_text[$urandom_range(0, 17)], 1'b0);
            13: begin
                push_text("{*", 1'b0);
                repeat ($urandom_range(0, 6)) begin
                    case ($urandom_range(0, 3))
                        0:       text_q.push_back({1'b0, 8'("*")});
                        1:       text_q.push_back({1'b0, 8'("}")});
                        default: text_q.push_back({1'b0, 8'($urandom_range(0, 255))});
                    endcase
                end
                push_text($urandom_range(0, 1) ? "**}" : "*}", 1'b0);
            end
            14: text_q.push_back({1'b0, 8'($urandom_range(0, 255))});
            15: text_q.push_back({1'b1, 8'($urandom_range(0, 255))});
            default: begin
                case ($urandom_range(0, 2))
                    0:       text_q.push_back({1'b0, 8'h20});
                    1:       text_q.push_back({1'b0, 8'h09});
                    default: text_q.push_back({1'b0, 8'h0A});
                endcase
            end
        endcase
    endfunction

    initial begin
        int sent;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: comment with doubled star, mixed-case keyword, pairs, lone
        // greater/brace/less, carriage return, top byte, end mark with junk char
        rx_mode = 1;
        push_text("{*a**}WhILE x:=0<>>{<", 1'b0);
        text_q.push_back({1'b0, 8'h0D});
        text_q.push_back({1'b0, 8'hFF});
        text_q.push_back({1'b1, 8'hFF});
        while (text_q.size() != 0) send_byte(text_q.pop_front());

        for (int ph = 0; ph < N_PHASES; ph++) begin
            if (ph > 0) begin
                wait_tokens_out();
                repeat (8) @(posedge i_clk);
                if (ph == N_PHASES - 1) begin
                    word_cfg[ph] = $urandom_range(0, 31);
                    num_cfg[ph]  = $urandom_range(0, 31);
                end
                write_reg(REG_MAX_WORD, LEN_W'(word_cfg[ph]));
                write_reg(REG_MAX_NUM, LEN_W'(num_cfg[ph]));
            end
            rx_mode = rx_modes[ph];
            gaps_on = (ph != 2 && ph != 5);
            // let the token queue fill up so the input has to stall
            if (ph == 2) rx_hold_req = 1'b1;
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                if (text_q.size() == 0) add_lexeme();
                send_byte(text_q.pop_front());
                sent++;
                if (ph == 1 && sent == 100) wait_tokens_out();
            end
            while (text_q.size() != 0) send_byte(text_q.pop_front());
            send_byte({1'b1, 8'h00});
        end

        wait_tokens_out();
        repeat (20) @(posedge i_clk);
        sb.mismatch_count += sb.expected_q.size();
        $display("Lexed %0d source bytes into %0d checked tokens under %0d limit settings,",
                 sb.n_bytes, sb.n_checked, N_PHASES);
        $display("with overlong runs, comments, operator pairs, stalls and end marks.");
        if (sb.mismatch_count == 0) begin
            $display("** keyword_lexer_byte_stream: PASSED **");
        end else begin
            $display("** keyword_lexer_byte_stream: FAILED **");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
design/klbs_pkg.sv
design/keyword_lexer_byte_stream.sv
design/keyword_lexer_byte_stream_chk.sv
dv/tb_top.sv
